// ----- hdl/chc_pkg.sv -----
// Shared types, constants and round functions for the ChaCha20 stream cipher core.
// No dependencies; imported by every module of the core.
package chc_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DATA_W        = 64;
    localparam int CNT_W         = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0_7    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_8_15   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_16_23  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_24_31  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_0_7  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_8_11 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR   = 3'd6;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [CNT_W-1:0] FULL_WORD_BYTES = 4'd8;

    typedef logic [15:0][31:0] t_state;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
        logic [31:0]      init_ctr;
    } t_cfg;

    typedef struct packed {
        logic [1:0][31:0]  ffwd;
        logic [2:0]        pos;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  vbytes;
        logic              last;
    } t_meta;

    typedef struct packed {
        t_state st;
        t_meta  meta;
    } t_lane;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_qr;

    function automatic t_state init_state(input t_cfg cfg, input logic [31:0] ctr);
        t_state s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            s[4+i] = cfg.key[i];
        end
        s[12] = ctr;
        s[13] = cfg.nonce[0];
        s[14] = cfg.nonce[1];
        s[15] = cfg.nonce[2];
        return s;
    endfunction

    function automatic t_qr qr_first(input t_qr q);
        t_qr r;
        r   = q;
        r.a = r.a + r.b;
        r.d = r.d ^ r.a;
        r.d = {r.d[15:0], r.d[31:16]};
        r.c = r.c + r.d;
        r.b = r.b ^ r.c;
        r.b = {r.b[19:0], r.b[31:20]};
        return r;
    endfunction

    function automatic t_qr qr_second(input t_qr q);
        t_qr r;
        r   = q;
        r.a = r.a + r.b;
        r.d = r.d ^ r.a;
        r.d = {r.d[23:0], r.d[31:24]};
        r.c = r.c + r.d;
        r.b = r.b ^ r.c;
        r.b = {r.b[24:0], r.b[31:25]};
        return r;
    endfunction

    // diag selects diagonal indexing; second selects the 8/7 half
    function automatic t_state half_round(input t_state s, input logic diag,
                                          input logic second);
        t_state r;
        t_qr    q;
        int     ib;
        int     ic;
        int     id;
        r = s;
        for (int i = 0; i < 4; i++) begin
            ib = diag ? 4 + ((i + 1) % 4) : 4 + i;
            ic = diag ? 8 + ((i + 2) % 4) : 8 + i;
            id = diag ? 12 + ((i + 3) % 4) : 12 + i;
            q.a = s[i];
            q.b = s[ib];
            q.c = s[ic];
            q.d = s[id];
            q = second ? qr_second(q) : qr_first(q);
            r[i]  = q.a;
            r[ib] = q.b;
            r[ic] = q.c;
            r[id] = q.d;
        end
        return r;
    endfunction

endpackage

// ----- hdl/chc_entry.sv -----
// Entry stage: block counter and word position tracking, initial state build.
// Depends on chc_pkg.
module chc_entry (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_start,
    input  logic                       i_last,
    input  logic [chc_pkg::DATA_W-1:0] i_data,
    input  logic [chc_pkg::CNT_W-1:0]  i_count,
    input  chc_pkg::t_cfg              i_cfg,
    output logic                       o_valid,
    output chc_pkg::t_lane             o_lane
);
    import chc_pkg::*;

    logic [31:0] r_ctr, n_ctr;
    logic [31:0] r_blk, n_blk;
    logic [2:0]  r_pos, n_pos;
    logic        r_ready, n_ready;
    logic        r_valid;
    t_lane       r_lane;
    t_cfg        r_bcfg;

    logic [31:0]      cnt_eff;
    logic             ready_eff;
    logic [2:0]       use_pos;
    logic [CNT_W-1:0] vbytes;
    logic             accept;
    t_cfg             blk_cfg;
    t_state           init;

    assign accept = i_valid && i_en;

    always_comb begin
        cnt_eff   = i_start ? i_cfg.init_ctr : r_ctr;
        ready_eff = r_ready && !i_start;
        if (!ready_eff) begin
            n_blk   = cnt_eff;
            use_pos = 3'd0;
            n_ctr   = cnt_eff + 32'd1;
            blk_cfg = i_cfg;
        end else begin
            n_blk   = r_blk;
            use_pos = r_pos;
            n_ctr   = cnt_eff;
            blk_cfg = r_bcfg;
        end
        init = init_state(blk_cfg, n_blk);
        if (i_last) begin
            n_pos   = 3'd0;
            n_ready = 1'b0;
        end else begin
            n_pos   = use_pos + 3'd1;
            n_ready = (use_pos != 3'd7);
        end
        if (i_last && i_count >= 4'd1 && i_count <= FULL_WORD_BYTES) begin
            vbytes = i_count;
        end else begin
            vbytes = FULL_WORD_BYTES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr   <= '0;
            r_blk   <= '0;
            r_pos   <= '0;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_ctr   <= n_ctr;
                r_blk   <= n_blk;
                r_pos   <= n_pos;
                r_ready <= n_ready;
            end
            if (i_en) begin
                r_valid <= i_valid;
            end
        end
    end

    // hold the key and nonce of the current block
    always_ff @(posedge i_clk) begin
        if (accept && !ready_eff) begin
            r_bcfg <= i_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane.st          <= init;
            r_lane.meta.ffwd   <= {init[{use_pos, 1'b1}], init[{use_pos, 1'b0}]};
            r_lane.meta.pos    <= use_pos;
            r_lane.meta.data   <= i_data;
            r_lane.meta.vbytes <= vbytes;
            r_lane.meta.last   <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// ----- hdl/chc_dround.sv -----
// One ChaCha double round as four registered half-round stages.
// Depends on chc_pkg.
module chc_dround (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  chc_pkg::t_lane i_lane,
    output logic           o_valid,
    output chc_pkg::t_lane o_lane
);
    import chc_pkg::*;

    logic [3:0] r_valid;
    t_lane      r_lane [4];
    t_lane      n_lane [4];

    always_comb begin
        n_lane[0]    = i_lane;
        n_lane[0].st = half_round(i_lane.st, 1'b0, 1'b0);
        n_lane[1]    = r_lane[0];
        n_lane[1].st = half_round(r_lane[0].st, 1'b0, 1'b1);
        n_lane[2]    = r_lane[1];
        n_lane[2].st = half_round(r_lane[1].st, 1'b1, 1'b0);
        n_lane[3]    = r_lane[2];
        n_lane[3].st = half_round(r_lane[2].st, 1'b1, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_lane[i] <= n_lane[i];
            end
        end
    end

    assign o_valid = r_valid[3];
    assign o_lane  = r_lane[3];

endmodule

// ----- hdl/chc_output.sv -----
// Output stage: feed-forward add, keystream word select, XOR, byte mask, result register.
// Owns the pipeline advance signal. Depends on chc_pkg.
module chc_output (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  chc_pkg::t_lane             i_lane,
    input  logic                       i_ready,
    output logic                       o_en,
    output logic                       o_valid,
    output logic [chc_pkg::DATA_W-1:0] o_data,
    output logic [chc_pkg::CNT_W-1:0]  o_vbytes,
    output logic                       o_last
);
    import chc_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  r_vbytes;
    logic              r_last;

    logic [3:0]        idx_lo;
    logic [3:0]        idx_hi;
    logic [31:0]       ks_lo;
    logic [31:0]       ks_hi;
    logic [DATA_W-1:0] n_data;
    logic              load;

    assign load = i_valid && (!r_valid || i_ready);
    assign o_en = !i_valid || !r_valid || i_ready;

    always_comb begin
        idx_lo = {i_lane.meta.pos, 1'b0};
        idx_hi = {i_lane.meta.pos, 1'b1};
        ks_lo  = i_lane.st[idx_lo] + i_lane.meta.ffwd[0];
        ks_hi  = i_lane.st[idx_hi] + i_lane.meta.ffwd[1];
        n_data = i_lane.meta.data ^ {ks_hi, ks_lo};
        for (int b = 0; b < 8; b++) begin
            if (4'(b) >= i_lane.meta.vbytes) begin
                n_data[8*b +: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data   <= n_data;
            r_vbytes <= i_lane.meta.vbytes;
            r_last   <= i_lane.meta.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_vbytes = r_vbytes;
    assign o_last   = r_last;

endmodule

// ----- hdl/chacha20_stream_cipher_core.sv -----
// ChaCha20 stream cipher core: configuration registers, entry stage, round pipeline, output.
// Path from input transaction to tvalid: entry register, the half-round stages of all 20 rounds, output register.
// Throughput: one 64-bit word per cycle; each round pipeline stage holds one half round.
// The whole pipeline holds while a result waits and no bubble sits at its tail.
// Reset: synchronous active low; clears config, counter, position and all valid bits.
// Depends on chc_pkg, chc_entry, chc_dround, chc_output.
module chacha20_stream_cipher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // data_in[63:0], byte_count[67:64], zero pad [71:68]
    input  logic [chc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // start_message
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // data_out[63:0], valid_bytes[67:64], zero pad [71:68]
    output logic [chc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [chc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [chc_pkg::DATA_W-1:0]    i_cfg_data
);
    import chc_pkg::*;

    t_cfg r_cfg;

    logic                   en;
    logic [DOUBLE_ROUNDS:0] w_valid;
    t_lane                  w_lane [DOUBLE_ROUNDS+1];
    logic [DATA_W-1:0]      out_data;
    logic [CNT_W-1:0]       out_vbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_0_7:    r_cfg.key[1:0]  <= i_cfg_data;
                CFG_KEY_8_15:   r_cfg.key[3:2]  <= i_cfg_data;
                CFG_KEY_16_23:  r_cfg.key[5:4]  <= i_cfg_data;
                CFG_KEY_24_31:  r_cfg.key[7:6]  <= i_cfg_data;
                CFG_NONCE_0_7:  r_cfg.nonce[1:0] <= i_cfg_data;
                CFG_NONCE_8_11: r_cfg.nonce[2]  <= i_cfg_data[31:0];
                CFG_INIT_CTR:   r_cfg.init_ctr  <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = en;

    chc_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_start (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .i_data  (s_axis_tdata[DATA_W-1:0]),
        .i_count (s_axis_tdata[DATA_W+CNT_W-1:DATA_W]),
        .i_cfg   (r_cfg),
        .o_valid (w_valid[0]),
        .o_lane  (w_lane[0])
    );

    for (genvar g = 0; g < DOUBLE_ROUNDS; g++) begin : g_dround
        chc_dround u_dround (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    chc_output u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[DOUBLE_ROUNDS]),
        .i_lane   (w_lane[DOUBLE_ROUNDS]),
        .i_ready  (m_axis_tready),
        .o_en     (en),
        .o_valid  (m_axis_tvalid),
        .o_data   (out_data),
        .o_vbytes (out_vbytes),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W-DATA_W-CNT_W){1'b0}}, out_vbytes, out_data};

endmodule
